@@ sv/pcss_pkg.sv @@
package pcss_pkg;

   localparam int MaxChannels = 1024;
   localparam int ChanW = $clog2(MaxChannels);
   localparam int BlockLanes = 8;
   localparam int LaneW = 3;

   // exact sum grid: product bits reach 2^80 on a 2^-48 grid, one more bit for the carry
   localparam int MagW = 81;

   localparam logic [15:0] HalfOne = 16'h3C00;
   localparam logic [15:0] HalfNan = 16'h7E00;
   localparam logic [15:0] HalfInf = 16'h7C00;

   localparam logic [1:0] LayoutPlanar = 2'd0;
   localparam logic [1:0] LayoutChLast = 2'd1;
   localparam logic [1:0] LayoutBlock8 = 2'd2;

   localparam logic [2:0] RegLayout = 3'd0;
   localparam logic [2:0] RegChannels = 3'd1;
   localparam logic [2:0] RegElements = 3'd2;
   localparam logic [2:0] RegBatches = 3'd3;
   localparam logic [2:0] RegUseAlpha = 3'd4;
   localparam logic [2:0] RegUseBeta = 3'd5;

   // one queued sample bound for the arithmetic back end
   typedef struct packed {
      logic [ChanW-1:0] chan;
      logic             chan_ok;
      logic [15:0]      sample;
      logic             tensor_end;
   } work_type;

   // one coefficient write
   typedef struct packed {
      logic [ChanW-1:0] chan;
      logic [15:0]      alpha;
      logic [15:0]      beta;
   } coef_type;

   function automatic logic [6:0] lead_pos(input logic [MagW-1:0] v);
      logic [6:0] p;
      p = 7'd0;
      for (int i = 0; i < MagW; i++) begin
         if (v[i]) p = 7'(i);
      end
      return p;
   endfunction

endpackage

@@ sv/pcss_front.sv @@
module pcss_front
   import pcss_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic             in_mode,
   input  logic [ChanW-1:0] in_chan,
   input  logic [15:0]      in_alpha,
   input  logic [15:0]      in_beta,
   input  logic [15:0]      in_sample,
   input  logic             q_ready,
   input  logic             q_valid,
   input  logic [1:0]       layout,
   input  logic [10:0]      channel_count,
   input  logic [15:0]      elems_per_chan,
   input  logic [8:0]       batch_count,
   output logic             in_ready,
   output logic             q_push,
   output work_type         q_data,
   output logic             coef_we,
   output coef_type         coef
);

   logic [15:0] elem_ff, elem_in;
   logic [10:0] chan_ff, chan_in;
   logic [LaneW-1:0] lane_ff, lane_in;
   logic [7:0] batch_ff, batch_in;

   logic [10:0] cc;
   logic [16:0] epc;
   logic [8:0] bc;
   logic [1:0] lay;
   logic el_last, b_last, ch_last, lane_last, take;
   logic [11:0] ch_sum;

   always_comb begin
      cc = (channel_count == 11'd0) ? 11'd1 :
           (channel_count > 11'(MaxChannels)) ? 11'(MaxChannels) : channel_count;
      epc = (elems_per_chan == 16'd0) ? 17'd1 : {1'b0, elems_per_chan};
      bc = (batch_count == 9'd0) ? 9'd1 : (batch_count > 9'd256) ? 9'd256 : batch_count;
      lay = (layout == LayoutChLast || layout == LayoutBlock8) ? layout : LayoutPlanar;
      ch_sum = (lay == LayoutBlock8) ? ({1'b0, chan_ff} + {9'd0, lane_ff}) : {1'b0, chan_ff};
      el_last = ({1'b0, elem_ff} + 17'd1) >= epc;
      b_last = ({1'b0, batch_ff} + 9'd1) >= bc;
      if (lay == LayoutBlock8) begin
         ch_last = ({1'b0, chan_ff} + 12'(BlockLanes)) >= {1'b0, cc};
         lane_last = (lane_ff == LaneW'(BlockLanes - 1));
      end else begin
         ch_last = ({1'b0, chan_ff} + 12'd1) >= {1'b0, cc};
         lane_last = 1'b1;
      end
   end

   // hold a coefficient beat until every queued sample has read the tables
   assign in_ready = in_mode ? q_ready : !q_valid;
   assign take = in_valid && in_ready;
   assign coef_we = take && !in_mode;
   assign coef = '{chan: in_chan, alpha: in_alpha, beta: in_beta};
   assign q_push = take && in_mode;
   assign q_data = '{chan: ch_sum[ChanW-1:0], chan_ok: ch_sum < {1'b0, cc},
                     sample: in_sample,
                     tensor_end: el_last && b_last && ch_last && lane_last};

   always_comb begin
      elem_in = elem_ff;
      chan_in = chan_ff;
      lane_in = lane_ff;
      batch_in = batch_ff;
      if (q_push) begin
         case (lay)
            LayoutChLast: begin
               if (!ch_last) chan_in = chan_ff + 11'd1;
               else begin
                  chan_in = '0;
                  if (!el_last) elem_in = elem_ff + 16'd1;
                  else begin
                     elem_in = '0;
                     batch_in = b_last ? 8'd0 : batch_ff + 8'd1;
                  end
               end
            end
            LayoutBlock8: begin
               if (!lane_last) lane_in = lane_ff + LaneW'(1);
               else begin
                  lane_in = '0;
                  if (!el_last) elem_in = elem_ff + 16'd1;
                  else begin
                     elem_in = '0;
                     if (!ch_last) chan_in = chan_ff + 11'(BlockLanes);
                     else begin
                        chan_in = '0;
                        batch_in = b_last ? 8'd0 : batch_ff + 8'd1;
                     end
                  end
               end
            end
            default: begin
               if (!el_last) elem_in = elem_ff + 16'd1;
               else begin
                  elem_in = '0;
                  if (!ch_last) chan_in = chan_ff + 11'd1;
                  else begin
                     chan_in = '0;
                     batch_in = b_last ? 8'd0 : batch_ff + 8'd1;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elem_ff <= '0;
         chan_ff <= '0;
         lane_ff <= '0;
         batch_ff <= '0;
      end else begin
         elem_ff <= elem_in;
         chan_ff <= chan_in;
         lane_ff <= lane_in;
         batch_ff <= batch_in;
      end
   end

endmodule

@@ sv/pcss_queue.sv @@
module pcss_queue
   import pcss_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   output logic     push_ready,
   output logic     pop_valid,
   output work_type pop_data,
   input  logic     pop
);

   // two-entry queue: accepts while full as long as a pop happens the same cycle
   work_type mem_ff [2];
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign pop_valid = cnt_ff != 2'd0;
   assign pop_data = mem_ff[rd_ff];
   assign push_ready = cnt_ff != 2'd2 || pop;

   always_comb begin
      rd_in = pop ? !rd_ff : rd_ff;
      wr_in = push ? !wr_ff : wr_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ sv/pcss_back.sv @@
module pcss_back
   import pcss_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     use_alpha,
   input  logic     use_beta,
   input  logic     coef_we,
   input  coef_type coef,
   input  logic     q_valid,
   input  work_type q_data,
   output logic     q_pop,
   output logic     out_valid,
   output logic [15:0] out_result,
   output logic     out_end,
   input  logic     out_ready
);

   logic [15:0] alpha_mem [MaxChannels];
   logic [15:0] beta_mem [MaxChannels];

   // stage valids: s1 table read, s2 product, s3 align/add, out register (round feeds it)
   logic v1_ff, v2_ff, v3_ff, vo_ff;
   logic adv;
   assign adv = !vo_ff || out_ready;
   assign q_pop = q_valid && adv;

   // stage 1
   logic [15:0] ra_ff, rb_ff, x1_ff;
   logic ua1_ff, ub1_ff, e1_ff;
   always_ff @(posedge clock) begin
      if (coef_we) begin
         alpha_mem[coef.chan] <= coef.alpha;
         beta_mem[coef.chan] <= coef.beta;
      end
      if (adv) begin
         ra_ff <= alpha_mem[q_data.chan];
         rb_ff <= beta_mem[q_data.chan];
         ua1_ff <= use_alpha && q_data.chan_ok;
         ub1_ff <= use_beta && q_data.chan_ok;
         x1_ff <= q_data.sample;
         e1_ff <= q_data.tensor_end;
      end
   end

   // stage 2: specials and mantissa product
   logic [15:0] a, b, x;
   logic a_sp, x_sp, b_sp, a_z, x_z, sp, spec, bias_zero;
   logic [15:0] spec_val;
   logic [10:0] ma, mx, mb;
   logic signed [7:0] ea, ex, eb;
   always_comb begin
      a = ua1_ff ? ra_ff : HalfOne;
      b = ub1_ff ? rb_ff : 16'h0000;
      x = x1_ff;
      a_sp = a[14:10] == 5'd31;
      x_sp = x[14:10] == 5'd31;
      b_sp = b[14:10] == 5'd31;
      a_z = a[14:0] == '0;
      x_z = x[14:0] == '0;
      sp = a[15] ^ x[15];
      ma = (a[14:10] == 5'd0) ? {1'b0, a[9:0]} : {1'b1, a[9:0]};
      mx = (x[14:10] == 5'd0) ? {1'b0, x[9:0]} : {1'b1, x[9:0]};
      mb = (b[14:10] == 5'd0) ? {1'b0, b[9:0]} : {1'b1, b[9:0]};
      ea = (a[14:10] == 5'd0) ? -8'sd24 : $signed({3'd0, a[14:10]}) - 8'sd25;
      ex = (x[14:10] == 5'd0) ? -8'sd24 : $signed({3'd0, x[14:10]}) - 8'sd25;
      eb = (b[14:10] == 5'd0) ? -8'sd24 : $signed({3'd0, b[14:10]}) - 8'sd25;
      bias_zero = mb == 11'd0;
      spec = 1'b1;
      spec_val = HalfNan;
      if ((a_sp && a[9:0] != 0) || (x_sp && x[9:0] != 0) || (b_sp && b[9:0] != 0))
         spec_val = HalfNan;
      else if ((a_sp && x_z) || (x_sp && a_z)) spec_val = HalfNan;
      else if (a_sp || x_sp) begin
         if (b_sp && b[15] != sp) spec_val = HalfNan;
         else spec_val = {sp, HalfInf[14:0]};
      end else if (b_sp) spec_val = b;
      else if (a_z || x_z) spec_val = bias_zero ? {sp && b[15], 15'd0} : b;
      else spec = 1'b0;
   end

   logic [21:0] mp2_ff;
   logic signed [8:0] ep2_ff, eb2_ff;
   logic [10:0] mb2_ff;
   logic sp2_ff, sb2_ff, spec2_ff, e2_ff;
   logic [15:0] sv2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         mp2_ff <= ma * mx;
         ep2_ff <= 9'(ea) + 9'(ex);
         eb2_ff <= 9'(eb);
         mb2_ff <= mb;
         sp2_ff <= sp;
         sb2_ff <= b[15];
         spec2_ff <= spec;
         sv2_ff <= spec_val;
         e2_ff <= e1_ff;
      end
   end

   // stage 3: align on a common grid and add; product exponents stay in [-48,10]
   // base = -48 fixes the grid; the sum is exact since everything fits in MagW bits
   logic [MagW-1:0] vp, vb, mag;
   logic sgn;
   always_comb begin
      vp = MagW'(mp2_ff) << 6'(ep2_ff + 9'sd48);
      vb = MagW'(mb2_ff) << 6'(eb2_ff + 9'sd48);
      sgn = sp2_ff;
      if (sp2_ff == sb2_ff) mag = vp + vb;
      else if (vp >= vb) mag = vp - vb;
      else begin
         mag = vb - vp;
         sgn = sb2_ff;
      end
   end

   logic [MagW-1:0] mag3_ff;
   logic sg3_ff, spec3_ff, e3_ff;
   logic [15:0] sv3_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         mag3_ff <= mag;
         sg3_ff <= sgn;
         spec3_ff <= spec2_ff;
         sv3_ff <= sv2_ff;
         e3_ff <= e2_ff;
      end
   end

   // stage 4: leading one, normalize and round; value = mag * 2^-48
   logic [6:0] lp;
   logic signed [7:0] top, q;
   logic [6:0] sh;
   logic [MagW-1:0] shifted, rem, halfw;
   logic [11:0] m;
   logic [15:0] y;
   always_comb begin
      lp = lead_pos(mag3_ff);
      top = $signed({1'b0, lp}) - 8'sd48;
      q = top - 8'sd10;
      if (q < -8'sd24) q = -8'sd24;
      sh = 7'(q + 8'sd48);
      shifted = mag3_ff >> sh;
      rem = mag3_ff & ((MagW'(1) << sh) - MagW'(1));
      halfw = MagW'(1) << (sh - 7'd1);
      m = shifted[11:0];
      if (rem > halfw || (rem == halfw && m[0])) m = m + 12'd1;
      if (m == 12'd2048) begin
         m = 12'd1024;
         q = q + 8'sd1;
      end
      if (spec3_ff) y = sv3_ff;
      else if (mag3_ff == '0) y = 16'h0000;
      else if (top > 8'sd15) y = {sg3_ff, HalfInf[14:0]};
      else if (m < 12'd1024) y = {sg3_ff, 5'd0, m[9:0]};
      else if (q + 8'sd25 >= 8'sd31) y = {sg3_ff, HalfInf[14:0]};
      else y = {sg3_ff, 5'(q + 8'sd25), m[9:0]};
   end

   logic [15:0] res_ff;
   logic end_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= y;
         end_ff <= e3_ff;
      end
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= q_pop;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         vo_ff <= v3_ff;
      end
   end

   assign out_valid = vo_ff;
   assign out_result = res_ff;
   assign out_end = end_ff;

endmodule

@@ sv/per_channel_fp16_scale_shift.sv @@
// Per-channel half-precision scale and bias: result = alpha[c]*sample + beta[c] with one
// fused round to nearest even. A beat with tuser = 0 writes the alpha/beta pair of one
// channel and gives no result; a beat with tuser = 1 is a tensor sample and gives exactly
// one result beat, with rsp_tlast set on the last sample of the tensor. The front end walks
// the position counters for the configured layout (planar, channel last, or blocks of
// eight channels) and hands each sample to a two-entry queue; the back end reads the
// coefficient tables and runs a three-stage multiply-add pipeline into an output register.
// Samples stream at one beat per cycle while the output does not stall; an output stall
// holds the whole back end. A coefficient beat is held off until the queue is empty, so
// after samples it waits for the queue to drain plus any output stall. Tables hold
// garbage until written; write the coefficients of every channel used before streaming
// data. Configure only while the block is idle.
module per_channel_fp16_scale_shift
   import pcss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // coef_channel[9:0], alpha_bits[25:10], beta_bits[41:26],
                                    // sample[57:42], zero pad [63:58]
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // result
   output logic        rsp_tlast,   // tensor_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic [1:0] layout_ff;
   logic [10:0] chans_ff;
   logic [15:0] elems_ff;
   logic [8:0] batches_ff;
   logic ua_ff, ub_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff <= LayoutPlanar;
         chans_ff <= 11'd1;
         elems_ff <= 16'd1;
         batches_ff <= 9'd1;
         ua_ff <= 1'b1;
         ub_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            RegLayout:   layout_ff <= csr_data[1:0];
            RegChannels: chans_ff <= csr_data[10:0];
            RegElements: elems_ff <= csr_data;
            RegBatches:  batches_ff <= csr_data[8:0];
            RegUseAlpha: ua_ff <= csr_data[0];
            RegUseBeta:  ub_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic q_push, q_ready, q_valid, q_pop, coef_we;
   work_type q_in, q_out;
   coef_type coef;

   pcss_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_mode(req_tuser),
      .in_chan(req_tdata[9:0]), .in_alpha(req_tdata[25:10]), .in_beta(req_tdata[41:26]),
      .in_sample(req_tdata[57:42]),
      .q_ready, .q_valid, .layout(layout_ff), .channel_count(chans_ff),
      .elems_per_chan(elems_ff), .batch_count(batches_ff),
      .in_ready(req_tready), .q_push, .q_data(q_in), .coef_we, .coef
   );

   pcss_queue u_queue (
      .clock, .reset, .push(q_push), .push_data(q_in), .push_ready(q_ready),
      .pop_valid(q_valid), .pop_data(q_out), .pop(q_pop)
   );

   pcss_back u_back (
      .clock, .reset, .use_alpha(ua_ff), .use_beta(ub_ff), .coef_we, .coef,
      .q_valid, .q_data(q_out), .q_pop,
      .out_valid(rsp_tvalid), .out_result(rsp_tdata), .out_end(rsp_tlast),
      .out_ready(rsp_tready)
   );

endmodule

@@ sv/pcss_checker.sv @@
module pcss_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("rsp hold");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tlast)) else $error("rsp last hold");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid) else $error("rsp after reset");
endmodule

bind per_channel_fp16_scale_shift pcss_checker u_chk (.*);

@@ dv/tb.sv @@
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pcss_pkg::*;

   typedef struct {
      logic [15:0] result;
      logic        tensor_end;
   } scaled_type;

   // Tracks tables, position counters and registers; predicts one result per sample.
   class ScaleShiftBook;
      logic [15:0] alpha_tab [MaxChannels];
      logic [15:0] beta_tab [MaxChannels];
      int unsigned batch_pos, chan_pos, elem_pos, lane_pos;
      int unsigned lay_reg, chan_reg, elem_reg, batch_reg, ua_reg, ub_reg;
      scaled_type  owed [$];
      int          mismatches;
      int          checked;
      int          ends_seen;

      function new();
         batch_pos = 0; chan_pos = 0; elem_pos = 0; lane_pos = 0;
         lay_reg = 0; chan_reg = 1; elem_reg = 1; batch_reg = 1; ua_reg = 1; ub_reg = 1;
         mismatches = 0; checked = 0; ends_seen = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [15:0] val);
         case (idx)
            RegLayout:   lay_reg = val & 16'd3;
            RegChannels: chan_reg = val & 16'd2047;
            RegElements: elem_reg = val;
            RegBatches:  batch_reg = val & 16'd511;
            RegUseAlpha: ua_reg = val & 16'd1;
            RegUseBeta:  ub_reg = val & 16'd1;
            default: ;
         endcase
      endfunction

      function int bit_len(longint unsigned v);
         int n;
         n = 0;
         while (v != 0) begin
            n++;
            v = v >> 1;
         end
         return n;
      endfunction

      function logic [15:0] round_half(bit sgn, longint unsigned mag, int ex);
         logic [15:0] s;
         int top, q, sh;
         longint unsigned m, rem, halfway;
         s = sgn ? 16'h8000 : 16'h0000;
         top = ex + bit_len(mag) - 1;
         if (top > 15) return s | HalfInf;
         q = top - 10;
         if (q < -24) q = -24;
         sh = q - ex;
         if (sh <= 0) begin
            m = mag << (-sh);
         end else if (sh > 64) begin
            m = 0;
         end else begin
            halfway = 64'd1 << (sh - 1);
            if (sh == 64) begin
               m = 0;
               rem = mag;
            end else begin
               m = mag >> sh;
               rem = mag & ((64'd1 << sh) - 1);
            end
            if (rem > halfway || (rem == halfway && m[0])) m++;
         end
         if (m == 2048) begin
            m = 1024;
            q++;
         end
         if (m < 1024) return s | 16'(m);
         if (q + 25 >= 31) return s | HalfInf;
         return s | 16'((q + 25) << 10) | 16'(m & 1023);
      endfunction

      function longint unsigned mant(logic [15:0] h);
         return (h[14:10] == 0) ? 64'(h[9:0]) : 64'({1'b1, h[9:0]});
      endfunction

      function int expo(logic [15:0] h);
         return (h[14:10] == 0) ? -24 : int'(h[14:10]) - 25;
      endfunction

      function longint unsigned align(longint unsigned m, int e, int base);
         int sh;
         sh = e - base;
         if (sh >= 0) return m << sh;
         if (-sh >= 64) return (m != 0) ? 64'd1 : 64'd0;
         return (m >> (-sh)) | ((m & ((64'd1 << (-sh)) - 1)) != 0 ? 64'd1 : 64'd0);
      endfunction

      // Fused a*x + b with a single round to nearest even.
      function logic [15:0] fused_madd(logic [15:0] a, logic [15:0] x, logic [15:0] b);
         bit a_sp, x_sp, b_sp, a_z, x_z, sp;
         longint unsigned mp, mb, vp, vb, mag;
         int ep, eb, tp, tb, base;
         a_sp = a[14:10] == 5'h1F;
         x_sp = x[14:10] == 5'h1F;
         b_sp = b[14:10] == 5'h1F;
         a_z = a[14:0] == 0;
         x_z = x[14:0] == 0;
         if ((a_sp && a[9:0] != 0) || (x_sp && x[9:0] != 0) || (b_sp && b[9:0] != 0))
            return HalfNan;
         if ((a_sp && x_z) || (x_sp && a_z)) return HalfNan;
         sp = a[15] ^ x[15];
         if (a_sp || x_sp) begin
            if (b_sp && b[15] != sp) return HalfNan;
            return {sp, 15'h7C00};
         end
         if (b_sp) return b;
         mp = mant(a) * mant(x);
         ep = expo(a) + expo(x);
         mb = mant(b);
         eb = expo(b);
         if (mp == 0) begin
            if (mb == 0) return (sp && b[15]) ? 16'h8000 : 16'h0000;
            return b;
         end
         if (mb == 0) return round_half(sp, mp, ep);
         tp = ep + bit_len(mp) - 1;
         tb = eb + bit_len(mb) - 1;
         base = ((tp > tb) ? tp : tb) - 62;
         vp = align(mp, ep, base);
         vb = align(mb, eb, base);
         if (sp == b[15]) mag = vp + vb;
         else if (vp >= vb) mag = vp - vb;
         else begin
            mag = vb - vp;
            sp = b[15];
         end
         if (mag == 0) return 16'h0000;
         return round_half(sp, mag, base);
      endfunction

      // Note one accepted request beat; a sample queues its expected result.
      function void note_beat(bit mode, logic [9:0] ch_in, logic [15:0] a_in,
                              logic [15:0] b_in, logic [15:0] smp);
         int unsigned cc, epc, bc, lay, ch;
         bit el_last, b_last, ch_last, lane_last;
         logic [15:0] a, b;
         scaled_type e;
         if (!mode) begin
            alpha_tab[ch_in] = a_in;
            beta_tab[ch_in] = b_in;
            return;
         end
         cc = (chan_reg == 0) ? 1 : chan_reg;
         if (cc > MaxChannels) cc = MaxChannels;
         epc = (elem_reg == 0) ? 1 : elem_reg;
         bc = (batch_reg == 0) ? 1 : batch_reg;
         if (bc > 256) bc = 256;
         lay = (lay_reg == LayoutChLast || lay_reg == LayoutBlock8) ? lay_reg : LayoutPlanar;
         ch = (lay == LayoutBlock8) ? chan_pos + lane_pos : chan_pos;
         a = (ua_reg != 0 && ch < cc) ? alpha_tab[ch] : HalfOne;
         b = (ub_reg != 0 && ch < cc) ? beta_tab[ch] : 16'h0000;
         e.result = fused_madd(a, smp, b);
         el_last = elem_pos + 1 >= epc;
         b_last = batch_pos + 1 >= bc;
         if (lay == LayoutBlock8) begin
            ch_last = chan_pos + BlockLanes >= cc;
            lane_last = lane_pos + 1 >= BlockLanes;
         end else begin
            ch_last = chan_pos + 1 >= cc;
            lane_last = 1;
         end
         e.tensor_end = el_last && b_last && ch_last && lane_last;
         // advance counters innermost first, per layout
         if (lay == LayoutPlanar) begin
            if (!el_last) elem_pos++;
            else begin
               elem_pos = 0;
               if (!ch_last) chan_pos++;
               else begin
                  chan_pos = 0;
                  batch_pos = b_last ? 0 : batch_pos + 1;
               end
            end
         end else if (lay == LayoutChLast) begin
            if (!ch_last) chan_pos++;
            else begin
               chan_pos = 0;
               if (!el_last) elem_pos++;
               else begin
                  elem_pos = 0;
                  batch_pos = b_last ? 0 : batch_pos + 1;
               end
            end
         end else begin
            if (!lane_last) lane_pos++;
            else begin
               lane_pos = 0;
               if (!el_last) elem_pos++;
               else begin
                  elem_pos = 0;
                  if (!ch_last) chan_pos += BlockLanes;
                  else begin
                     chan_pos = 0;
                     batch_pos = b_last ? 0 : batch_pos + 1;
                  end
               end
            end
         end
         owed.push_back(e);
      endfunction

      function void check_result(logic [15:0] got, logic got_end);
         scaled_type e;
         if (owed.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h last %b", got, got_end);
            return;
         end
         e = owed.pop_front();
         checked++;
         if (got_end === 1'b1) ends_seen++;
         if (got !== e.result || got_end !== e.tensor_end) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result mismatch: expected %h last %b, got %h last %b",
                        e.result, e.tensor_end, got, got_end);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   ScaleShiftBook book = new();
   int tx_idle_pct;
   int rx_idle_pct;
   int hold_start;
   int hold_left;
   int coef_beats;
   int sample_beats;

   per_channel_fp16_scale_shift dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Note each accepted request beat and check each accepted result beat.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         book.note_beat(req_tuser, req_tdata[9:0], req_tdata[25:10], req_tdata[41:26],
                        req_tdata[57:42]);
         if (req_tuser) sample_beats++;
         else coef_beats++;
      end
      if (!reset && rsp_tvalid && rsp_tready) book.check_result(rsp_tdata, rsp_tlast);
   end

   // Result side: random stalls, plus a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_start > 0) begin
         hold_left = hold_start;
         hold_start = 0;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // Pick a half value, biased toward zeros, infinities, NaNs, subnormals, values in [1,2) and the top finite exponent.
   function automatic logic [15:0] pick_half();
      logic [15:0] h;
      h = 16'($urandom);
      case ($urandom_range(0, 11))
         0: h = {h[15], 15'h0000};
         1: h = {h[15], 15'h7C00};
         2: h = {h[15], 5'h1F, h[9:0] | 10'h001};
         3: h = {h[15], 5'h00, h[9:0]};
         4: h = {h[15], 5'h0F, h[9:0]};
         5: h = {h[15], 5'h1E, h[9:0]};
         default: ;
      endcase
      return h;
   endfunction

   task automatic send_beat(bit mode, logic [9:0] ch, logic [15:0] a, logic [15:0] b,
                            logic [15:0] smp);
      logic [63:0] packed_beat;
      packed_beat = {6'b0, smp, b, a, ch};
      // optional idle cycles before the beat
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= packed_beat;
      do @(posedge clock); while (!req_tready);
   endtask

   // Leaves csr_valid high; the caller drops it after the last write.
   task automatic write_csr(logic [2:0] idx, logic [15:0] val);
      req_tvalid <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      book.write_reg(idx, val);
   endtask

   // Hold until every owed result is back, then let the pipeline drain.
   task automatic drain();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (book.owed.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (12) @(posedge clock);
   endtask

   initial begin
      #20ms;
      $display("timeout");
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      logic [15:0] edge_vals [12];
      int lay, cc, epc, bc, ua, ub, n_items;
      edge_vals = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E01, 16'h0001,
                    16'h7BFF, 16'hFBFF, 16'h3C00, 16'h83FF, 16'h7FFF, 16'h0400};
      tx_idle_pct = 13;
      rx_idle_pct = 82;
      hold_start = 0;
      hold_left = 0;
      coef_beats = 0;
      sample_beats = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_valid = 1'b0;
      csr_index = RegLayout;
      csr_data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every table entry so no sample can read an unwritten channel
      for (int c = 0; c < MaxChannels; c++)
         send_beat(1'b0, 10'(c), pick_half(), pick_half(), 16'($urandom));

      for (int p = 0; p < 12; p++) begin
         // idling regime: sender light/receiver heavy, then swapped, then none
         if (p < 4) begin
            tx_idle_pct = 13;
            rx_idle_pct = 82;
         end else if (p < 8) begin
            tx_idle_pct = 82;
            rx_idle_pct = 13;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         case (p)
            0: begin lay = 0; cc = 3;    epc = 4;     bc = 2;   ua = 1; ub = 1; end
            1: begin lay = 1; cc = 5;    epc = 2;     bc = 3;   ua = 1; ub = 1; end
            2: begin lay = 2; cc = 11;   epc = 3;     bc = 2;   ua = 1; ub = 1; end
            3: begin lay = 3; cc = 2;    epc = 3;     bc = 1;   ua = 1; ub = 0; end
            4: begin lay = 0; cc = 0;    epc = 0;     bc = 0;   ua = 0; ub = 1; end
            5: begin lay = 2; cc = 1024; epc = 1;     bc = 1;   ua = 1; ub = 1; end
            6: begin lay = 1; cc = 2047; epc = 1;     bc = 511; ua = 1; ub = 1; end
            7: begin lay = 0; cc = 1;    epc = 65535; bc = 256; ua = 0; ub = 0; end
            default: begin
               lay = $urandom_range(0, 3);
               cc = $urandom_range(1, 40);
               epc = $urandom_range(1, 6);
               bc = $urandom_range(1, 4);
               ua = $urandom_range(0, 1);
               ub = $urandom_range(0, 1);
            end
         endcase
         drain();
         write_csr(RegLayout, 16'(lay));
         write_csr(RegChannels, 16'(cc));
         write_csr(RegElements, 16'(epc));
         write_csr(RegBatches, 16'(bc));
         write_csr(RegUseAlpha, 16'(ua));
         write_csr(RegUseBeta, 16'(ub));
         csr_valid <= 1'b0;

         // stall the result side for a long stretch so the input backs up
         if (p == 5) hold_start = 400;

         if (p == 0) begin
            foreach (edge_vals[i]) send_beat(1'b1, '0, '0, '0, edge_vals[i]);
            send_beat(1'b0, 10'd1023, 16'h7C00, 16'hFC00, '0);
            send_beat(1'b0, 10'd0, 16'h0000, 16'h8000, '0);
         end
         n_items = (p == 5) ? 200 : 66;
         for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_beat(1'b0, 10'($urandom), pick_half(), pick_half(), 16'($urandom));
            else
               send_beat(1'b1, 10'($urandom), 16'($urandom), 16'($urandom), pick_half());
         end
      end

      drain();
      $display("covered %0d coefficient beats and %0d samples over all layouts,",
               coef_beats, sample_beats);
      $display("%0d results checked, %0d tensor ends, %0d mismatches",
               book.checked, book.ends_seen, book.mismatches);
      if (book.mismatches == 0 && book.owed.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
sv/pcss_pkg.sv
sv/pcss_front.sv
sv/pcss_queue.sv
sv/pcss_back.sv
sv/per_channel_fp16_scale_shift.sv
sv/pcss_checker.sv
dv/tb.sv
